/* rtl/core/tkpq_pkg.sv */
// Package for the three-key press qualifier.
// Key bit positions, register indexes, reset values and shared types.
// No dependencies.
`default_nettype none

package tkpq_pkg;

    localparam int unsigned CNT_W    = 16;
    localparam int unsigned NUM_KEYS = 3;
    localparam int unsigned CFG_IDX_W = 2;

    // key bit positions in the level, previous-level and block vectors
    localparam int unsigned KEY_SET = 0;
    localparam int unsigned KEY_UP  = 1;
    localparam int unsigned KEY_AV  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LONG_SET_TICKS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMBO_TICKS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIP_CLEAR_TICKS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRIP_RELOAD_TICKS = 2'd3;

    localparam logic [CNT_W-1:0] LONG_SET_TICKS_RST    = 16'd300;
    localparam logic [CNT_W-1:0] COMBO_TICKS_RST       = 16'd300;
    localparam logic [CNT_W-1:0] TRIP_CLEAR_TICKS_RST  = 16'd200;
    localparam logic [CNT_W-1:0] TRIP_RELOAD_TICKS_RST = 16'd100;

    typedef struct packed {
        logic [CNT_W-1:0] long_set_ticks;
        logic [CNT_W-1:0] combo_ticks;
        logic [CNT_W-1:0] trip_clear_ticks;
        logic [CNT_W-1:0] trip_reload_ticks;
    } tkpq_cfg_t;

    typedef struct packed {
        logic [NUM_KEYS-1:0] prev_levels;
        logic [NUM_KEYS-1:0] block_flags;
        logic [CNT_W-1:0]    set_hold_count;
        logic [CNT_W-1:0]    combo_hold_count;
        logic [CNT_W-1:0]    av_hold_count;
    } tkpq_state_t;

    typedef struct packed {
        logic set_short;
        logic up_short;
        logic av_short;
        logic set_long;
        logic combo_long;
        logic trip_clear;
    } tkpq_evt_t;

endpackage

`default_nettype wire

/* rtl/core/tkpq_step.sv */
// One-tick update of the key qualifier: edge/short-press logic and hold counters.
// Purely combinational. Depends on tkpq_pkg.
`default_nettype none

module tkpq_step (
    input  wire logic [tkpq_pkg::NUM_KEYS-1:0] levels,
    input  wire tkpq_pkg::tkpq_cfg_t           cfg,
    input  wire tkpq_pkg::tkpq_state_t         cur,
    output tkpq_pkg::tkpq_state_t              nxt,
    output tkpq_pkg::tkpq_evt_t                evt
);

    logic [tkpq_pkg::NUM_KEYS-1:0] short_press;
    logic [tkpq_pkg::NUM_KEYS-1:0] blk_edge;
    logic s, u, a;
    logic set_fire, combo_fire, trip_fire;

    assign s = levels[tkpq_pkg::KEY_SET];
    assign u = levels[tkpq_pkg::KEY_UP];
    assign a = levels[tkpq_pkg::KEY_AV];

    // short press on release unless blocked; block clears on press edge
    always_comb begin
        for (int i = 0; i < tkpq_pkg::NUM_KEYS; i++) begin
            short_press[i] = !levels[i] && cur.prev_levels[i] && !cur.block_flags[i];
            if (short_press[i]) begin
                blk_edge[i] = 1'b1;
            end else if (levels[i] && !cur.prev_levels[i]) begin
                blk_edge[i] = 1'b0;
            end else begin
                blk_edge[i] = cur.block_flags[i];
            end
        end
    end

    assign set_fire   = s && (cur.set_hold_count >= cfg.long_set_ticks);
    assign combo_fire = a && u && (cur.combo_hold_count >= cfg.combo_ticks);
    assign trip_fire  = a && !u && (cur.av_hold_count >= cfg.trip_clear_ticks);

    always_comb begin
        nxt.prev_levels = levels;
        nxt.block_flags = blk_edge;
        if (set_fire) begin
            nxt.block_flags[tkpq_pkg::KEY_SET] = 1'b1;
        end
        if (combo_fire) begin
            nxt.block_flags[tkpq_pkg::KEY_AV] = 1'b1;
            nxt.block_flags[tkpq_pkg::KEY_UP] = 1'b1;
        end
        if (trip_fire) begin
            nxt.block_flags[tkpq_pkg::KEY_AV] = 1'b1;
        end

        // counts only rise below threshold, so +1 never wraps
        if (!s || set_fire) begin
            nxt.set_hold_count = '0;
        end else begin
            nxt.set_hold_count = cur.set_hold_count + 1'b1;
        end

        if (!(a && u) || combo_fire) begin
            nxt.combo_hold_count = '0;
        end else begin
            nxt.combo_hold_count = cur.combo_hold_count + 1'b1;
        end

        if (a && !u) begin
            if (trip_fire) begin
                nxt.av_hold_count = cfg.trip_reload_ticks;
            end else begin
                nxt.av_hold_count = cur.av_hold_count + 1'b1;
            end
        end else if (cur.av_hold_count != '0) begin
            nxt.av_hold_count = cur.av_hold_count - 1'b1;
        end else begin
            nxt.av_hold_count = cur.av_hold_count;
        end
    end

    assign evt.set_short  = short_press[tkpq_pkg::KEY_SET];
    assign evt.up_short   = short_press[tkpq_pkg::KEY_UP];
    assign evt.av_short   = short_press[tkpq_pkg::KEY_AV];
    assign evt.set_long   = set_fire;
    assign evt.combo_long = combo_fire;
    assign evt.trip_clear = trip_fire;

endmodule

`default_nettype wire

/* rtl/core/three_key_press_qualifier_unit.sv */
// Top level of the three-key press qualifier: stream ports, config registers,
// input register, key state and result register. Depends on tkpq_pkg, tkpq_step.
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_tvalid / s_tready  | s_tdata: key levels
//  m_      | out       | m_tvalid / m_tready  | m_tdata: six event pulses
//  cfg_    | in        | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// One transfer per cycle sustained while m_tready stays high.
// Key state is updated as an item moves from the input register to the
// result register, in a single combinational step (tkpq_step).
// Stalls on m_ hold both registers; s_tready stays high while either has room.
// aresetn is synchronous, active low; config returns to its reset values.
`default_nettype none

module three_key_press_qualifier_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,   // set_level, up_level, av_level, pad
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [7:0]                          m_tdata,   // set_short, up_short, av_short,
                                                           // set_long, combo_long, trip_clear, pad
    input  wire logic                           cfg_we,
    input  wire logic [tkpq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tkpq_pkg::CNT_W-1:0]     cfg_wdata
);

    tkpq_pkg::tkpq_cfg_t   cfg_reg;
    tkpq_pkg::tkpq_state_t state_reg, state_next;
    tkpq_pkg::tkpq_evt_t   evt_next;

    logic                          in_valid_reg;
    logic [tkpq_pkg::NUM_KEYS-1:0] in_levels_reg;
    logic                          out_valid_reg;
    logic [7:0]                    out_data_reg;
    logic                          out_free;
    logic                          advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_set_ticks    <= tkpq_pkg::LONG_SET_TICKS_RST;
            cfg_reg.combo_ticks       <= tkpq_pkg::COMBO_TICKS_RST;
            cfg_reg.trip_clear_ticks  <= tkpq_pkg::TRIP_CLEAR_TICKS_RST;
            cfg_reg.trip_reload_ticks <= tkpq_pkg::TRIP_RELOAD_TICKS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                tkpq_pkg::REG_LONG_SET_TICKS:    cfg_reg.long_set_ticks    <= cfg_wdata;
                tkpq_pkg::REG_COMBO_TICKS:       cfg_reg.combo_ticks       <= cfg_wdata;
                tkpq_pkg::REG_TRIP_CLEAR_TICKS:  cfg_reg.trip_clear_ticks  <= cfg_wdata;
                tkpq_pkg::REG_TRIP_RELOAD_TICKS: cfg_reg.trip_reload_ticks <= cfg_wdata;
                default: ;
            endcase
        end
    end

    tkpq_step u_step (
        .levels (in_levels_reg),
        .cfg    (cfg_reg),
        .cur    (state_reg),
        .nxt    (state_next),
        .evt    (evt_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_levels_reg <= s_tdata[tkpq_pkg::NUM_KEYS-1:0];
        end
        if (advance) begin
            out_data_reg <= {2'b00, evt_next.trip_clear, evt_next.combo_long,
                             evt_next.set_long, evt_next.av_short,
                             evt_next.up_short, evt_next.set_short};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

/* rtl/core/tkpq_checker.sv */
// Port-level checks for the three-key press qualifier, bound to the top level.
// Depends on three_key_press_qualifier_unit's port list only.
`default_nettype none

module tkpq_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    // result is held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // reset empties the result register
    a_rst_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // SET short needs a release, SET long needs SET held
    a_set_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[3]))
        else $error("set_short and set_long in one transfer");

    // combo needs UP held, trip clear needs UP released
    a_combo_trip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[4] && m_tdata[5]) && !(m_tdata[4] && m_tdata[1]))
        else $error("combo_long with trip_clear or up_short");

endmodule

bind three_key_press_qualifier_unit tkpq_checker u_tkpq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
